[sv/ilb_pkg.sv]
// Shared types and constants for the indexed list buffer.
`timescale 1ns / 1ps

package ilb_pkg;

    // Default number of list cells.
    localparam int DEFAULT_DEPTH = 16;

    // Fixed field widths of the request and result beats.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_PAD    = 3'd3,
        KIND_READ   = 3'd4
    } kind_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // One finished result, handed from the sequencer to the output stage.
    typedef struct packed {
        logic [POS_W-1:0]         entry_count;
        logic signed [WORD_W-1:0] read_word;
        status_t                  status;
    } result_t;

endpackage

[sv/ilb_ram.sv]
// Single-write, single-read list cell memory with registered read data.
`timescale 1ns / 1ps

module ilb_ram #(
    parameter int DEPTH = ilb_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [ilb_pkg::WORD_W-1:0]    wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [ilb_pkg::WORD_W-1:0]    rd_data
);

    logic [ilb_pkg::WORD_W-1:0] mem [DEPTH];
    logic [ilb_pkg::WORD_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ilb_seq.sv]
// Request sequencer: decodes one request and steps the cell memory through it.
`timescale 1ns / 1ps

module ilb_seq #(
    parameter int DEPTH = ilb_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request side.
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [ilb_pkg::KIND_W-1:0]    req_kind,
    input  logic [ilb_pkg::POS_W-1:0]     req_position,
    input  logic [ilb_pkg::WORD_W-1:0]    req_data_word,
    input  logic [ilb_pkg::POS_W-1:0]     req_target_count,
    // Result side.
    output logic                          res_valid,
    input  logic                          res_ready,
    output ilb_pkg::result_t              res,
    // Cell memory port.
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [ilb_pkg::WORD_W-1:0]    wr_data,
    output logic [AW-1:0]                 rd_addr,
    input  logic [ilb_pkg::WORD_W-1:0]    rd_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > ilb_pkg::POS_W) ? CW : ilb_pkg::POS_W;
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [XW-1:0] DEPTH_X  = XW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_DL_RD,
        S_DL_WR,
        S_PAD_WR,
        S_RD_CAP,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              idx_reg;
    logic [ilb_pkg::KIND_W-1:0] kind_reg;
    logic [ilb_pkg::POS_W-1:0]  pos_reg;
    logic [ilb_pkg::WORD_W-1:0] word_reg;
    logic [ilb_pkg::POS_W-1:0]  target_reg;
    ilb_pkg::status_t           status_reg;
    logic [ilb_pkg::WORD_W-1:0] rd_reg;

    // Operands brought to one common width for the shared compares.
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] tgt_x;
    logic          full;
    logic          pad_more;
    logic [CW:0]   idx_plus2;

    assign pos_x     = XW'(pos_reg);
    assign cnt_x     = XW'(count_reg);
    assign tgt_x     = XW'(target_reg);
    assign full      = (count_reg == DEPTH_C);
    assign pad_more  = (cnt_x < tgt_x) && !full;
    assign idx_plus2 = (CW + 1)'(idx_reg) + (CW + 1)'(2);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.status      = status_reg;
    assign res.read_word   = rd_reg;
    assign res.entry_count = ilb_pkg::POS_W'(count_reg);

    // Memory port control for the current step.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(count_reg);
        wr_data = word_reg;
        rd_addr = AW'(pos_reg);
        unique case (state_reg)
            S_EXEC: begin
                if (kind_reg == ilb_pkg::KIND_APPEND && !full) begin
                    wr_en = 1'b1;
                end
            end
            S_SH_RD: begin
                rd_addr = AW'(idx_reg - CW'(1));
            end
            S_SH_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg);
                wr_data = rd_data;
            end
            S_INS_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg);
            end
            S_DL_RD: begin
                rd_addr = AW'(idx_reg + CW'(1));
            end
            S_DL_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg);
                wr_data = rd_data;
            end
            S_PAD_WR: begin
                wr_en = pad_more;
            end
            default: begin
            end
        endcase
    end

    // State, list count and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        kind_reg   <= req_kind;
                        pos_reg    <= req_position;
                        word_reg   <= req_data_word;
                        target_reg <= req_target_count;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    status_reg <= ilb_pkg::ST_OK;
                    rd_reg     <= '0;
                    state_reg  <= S_DONE;
                    unique case (kind_reg)
                        ilb_pkg::KIND_APPEND: begin
                            if (full) begin
                                status_reg <= ilb_pkg::ST_FULL;
                            end else begin
                                count_reg <= count_reg + CW'(1);
                            end
                        end
                        ilb_pkg::KIND_INSERT: begin
                            if (pos_x > cnt_x) begin
                                status_reg <= ilb_pkg::ST_RANGE;
                            end else if (full) begin
                                status_reg <= ilb_pkg::ST_FULL;
                            end else begin
                                idx_reg   <= count_reg;
                                state_reg <= (cnt_x == pos_x) ? S_INS_WR : S_SH_RD;
                            end
                        end
                        ilb_pkg::KIND_DELETE: begin
                            if (count_reg == '0) begin
                                status_reg <= ilb_pkg::ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                status_reg <= ilb_pkg::ST_RANGE;
                            end else if ((XW + 1)'(pos_x) + (XW + 1)'(1)
                                         >= (XW + 1)'(cnt_x)) begin
                                // Last entry goes: nothing to move down.
                                count_reg <= count_reg - CW'(1);
                            end else begin
                                idx_reg   <= CW'(pos_reg);
                                state_reg <= S_DL_RD;
                            end
                        end
                        ilb_pkg::KIND_PAD: begin
                            if (tgt_x > DEPTH_X) begin
                                status_reg <= ilb_pkg::ST_FULL;
                            end
                            state_reg <= S_PAD_WR;
                        end
                        ilb_pkg::KIND_READ: begin
                            if (count_reg == '0) begin
                                status_reg <= ilb_pkg::ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                status_reg <= ilb_pkg::ST_RANGE;
                            end else begin
                                state_reg <= S_RD_CAP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // Move one entry up per read and write pair, top down.
                S_SH_RD: begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR: begin
                    idx_reg   <= idx_reg - CW'(1);
                    state_reg <= (XW'(idx_reg - CW'(1)) == pos_x) ? S_INS_WR : S_SH_RD;
                end
                S_INS_WR: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_DONE;
                end
                // Move one entry down per read and write pair, bottom up.
                S_DL_RD: begin
                    state_reg <= S_DL_WR;
                end
                S_DL_WR: begin
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_plus2 < (CW + 1)'(count_reg)) begin
                        state_reg <= S_DL_RD;
                    end else begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_DONE;
                    end
                end
                // One padding word per cycle until the target or the depth.
                S_PAD_WR: begin
                    if (pad_more) begin
                        count_reg <= count_reg + CW'(1);
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_RD_CAP: begin
                    rd_reg    <= rd_data;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/indexed_list_buffer_core.sv]
// Top level of the indexed list buffer: stream ports, sequencer, cell memory, output stage.
`timescale 1ns / 1ps

// An ordered list of up to DEPTH signed 32-bit words kept in a single-port-write,
// single-port-read memory and edited by a small sequencer, one memory step per cycle.
// Each request beat gives exactly one result beat. An insert moves count - position
// entries up and a delete moves count - position - 1 entries down; each move is a
// memory read followed by a write.
// The input side takes no new beat while a request is in progress; a finished
// result waits in an output register so the next request can start meanwhile.
module indexed_list_buffer_core #(
    parameter int DEPTH = ilb_pkg::DEFAULT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] kind, [7:3] position, [39:8] data_word, [44:40] target_count, [47:45] zero
    input  logic [47:0] s_tdata,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [33:2] read_word, [38:34] entry_count, [39] zero
    output logic [39:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);

    logic                       res_valid;
    logic                       res_ready;
    ilb_pkg::result_t           res;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [ilb_pkg::WORD_W-1:0] wr_data;
    logic [AW-1:0]              rd_addr;
    logic [ilb_pkg::WORD_W-1:0] rd_data;

    logic                       out_valid_reg;
    ilb_pkg::result_t           out_reg;

    ilb_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req_valid        (s_tvalid),
        .req_ready        (s_tready),
        .req_kind         (s_tdata[2:0]),
        .req_position     (s_tdata[7:3]),
        .req_data_word    (s_tdata[39:8]),
        .req_target_count (s_tdata[44:40]),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data)
    );

    ilb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: takes a result when empty or when its beat leaves this cycle.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.entry_count, out_reg.read_word, out_reg.status};

endmodule

[sim/list_result_checker.sv]
// Checker for the indexed list buffer: tracks the list, predicts each result beat and compares.
`timescale 1ns / 1ps

module list_result_checker #(
    parameter int DEPTH = ilb_pkg::DEFAULT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream, observed only.
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    // Result stream, observed only.
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    // Running totals for the test top.
    output int          error_count,
    output int          pending_count,
    output int          list_fill
);

    // Shadow copy of the list and the results still owed by the block.
    logic signed [ilb_pkg::WORD_W-1:0] shadow_cells [DEPTH];
    int                                shadow_held;
    ilb_pkg::result_t                  awaited_results [$];
    int                                mismatches;

    // Apply one request beat to the shadow list and return the result it must produce.
    function automatic ilb_pkg::result_t apply_list_request(input logic [47:0] beat);
        logic [ilb_pkg::KIND_W-1:0]        kind_bits;
        int                                pos;
        int                                target;
        int                                i;
        logic signed [ilb_pkg::WORD_W-1:0] word;
        ilb_pkg::result_t                  res;
        kind_bits     = beat[2:0];
        pos           = beat[7:3];
        word          = beat[39:8];
        target        = beat[44:40];
        res.status    = ilb_pkg::ST_OK;
        res.read_word = '0;
        case (kind_bits)
            ilb_pkg::KIND_APPEND: begin
                if (shadow_held >= DEPTH) begin
                    res.status = ilb_pkg::ST_FULL;
                end else begin
                    shadow_cells[shadow_held] = word;
                    shadow_held++;
                end
            end
            ilb_pkg::KIND_INSERT: begin
                // A bad index is reported ahead of a full list.
                if (pos > shadow_held) begin
                    res.status = ilb_pkg::ST_RANGE;
                end else if (shadow_held >= DEPTH) begin
                    res.status = ilb_pkg::ST_FULL;
                end else begin
                    for (i = shadow_held; i > pos; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[pos] = word;
                    shadow_held++;
                end
            end
            ilb_pkg::KIND_DELETE: begin
                if (shadow_held == 0) begin
                    res.status = ilb_pkg::ST_EMPTY;
                end else if (pos >= shadow_held) begin
                    res.status = ilb_pkg::ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < shadow_held; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_held--;
                end
            end
            ilb_pkg::KIND_PAD: begin
                // Fill up to the target, stopping at the depth; a target past it is an error.
                while (shadow_held < target && shadow_held < DEPTH) begin
                    shadow_cells[shadow_held] = word;
                    shadow_held++;
                end
                if (target > DEPTH)
                    res.status = ilb_pkg::ST_FULL;
            end
            ilb_pkg::KIND_READ: begin
                if (shadow_held == 0)
                    res.status = ilb_pkg::ST_EMPTY;
                else if (pos >= shadow_held)
                    res.status = ilb_pkg::ST_RANGE;
                else
                    res.read_word = shadow_cells[pos];
            end
            default: begin
                // Unused kinds leave the list alone.
            end
        endcase
        res.entry_count = shadow_held[ilb_pkg::POS_W-1:0];
        return res;
    endfunction

    // Compare result beats first, then record the expectation of a new request beat.
    always @(posedge aclk) begin
        ilb_pkg::result_t got;
        ilb_pkg::result_t want;
        if (!aresetn) begin
            awaited_results.delete();
            shadow_held = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status      = ilb_pkg::status_t'(m_tdata[1:0]);
                got.read_word   = m_tdata[33:2];
                got.entry_count = m_tdata[38:34];
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, %s %0d %0d %0d",
                             $time, "got status, word, count", got.status,
                             got.read_word, got.entry_count);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.read_word !== want.read_word) begin
                        mismatches++;
                        $display("%0t: read_word mismatch, expected %0d, got %0d",
                                 $time, want.read_word, got.read_word);
                    end
                    if (got.entry_count !== want.entry_count) begin
                        mismatches++;
                        $display("%0t: entry_count mismatch, expected %0d, got %0d",
                                 $time, want.entry_count, got.entry_count);
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(),
                                       apply_list_request(s_tdata));
        end
        error_count   <= mismatches;
        pending_count <= awaited_results.size();
        list_fill     <= shadow_held;
    end

endmodule

[sim/indexed_list_buffer_core_test.sv]
// Test top for the indexed list buffer: clock, reset, request and ready stimulus, verdict.
`timescale 1ns / 1ps

module indexed_list_buffer_core_test;

    localparam int          LIST_DEPTH    = ilb_pkg::DEFAULT_DEPTH;
    localparam int          RANDOM_ITEMS  = 850;
    localparam int          CALM_FROM     = 750;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          TAIL_CYCLES   = 40;
    localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
    localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
    localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX      = 32'h7FFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        calm;
    int          error_count;
    int          pending_count;
    int          list_fill;
    int          quiet_cycles;

    indexed_list_buffer_core #(
        .DEPTH (LIST_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_result_checker #(
        .DEPTH (LIST_DEPTH)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count),
        .list_fill     (list_fill)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pack one request beat: kind, position, data_word, target_count from the low bits up.
    function automatic logic [47:0] make_beat(input logic [2:0] kind_bits, input logic [4:0] pos,
                                              input logic [31:0] word, input logic [4:0] target);
        return {3'b000, target, word, pos, kind_bits};
    endfunction

    // Mostly random words, with the extremes mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Move to the next falling edge, sometimes with an idle burst first.
    task automatic next_slot();
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap      = $urandom_range(1, 8);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Present one beat and hold it until the block takes it.
    task automatic send_beat(input logic [47:0] beat);
        s_tdata  = beat;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic request(input logic [2:0] kind_bits, input logic [4:0] pos,
                           input logic [31:0] word, input logic [4:0] target);
        next_slot();
        send_beat(make_beat(kind_bits, pos, word, target));
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    // Receiver ready with random stall bursts, steady once the run calms down.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                stall    = $urandom_range(1, 8);
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("indexed_list_buffer_core_test: done, errors");
                $finish;
            end
        end
    end

    // Main stimulus.
    initial begin
        int          counted;
        int          pick;
        int          span;
        logic [2:0]  kind_bits;
        logic [4:0]  pos;
        logic [4:0]  target;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        calm         = 1'b0;
        counted      = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: empty list, edges of insert and delete, full list, padding cases.
        request(ilb_pkg::KIND_READ,   5'd0,  32'h1234_5678, 5'd0);
        request(ilb_pkg::KIND_DELETE, 5'd0,  32'h0,         5'd0);
        request(ilb_pkg::KIND_INSERT, 5'd1,  32'h0BAD_0BAD, 5'd0);
        request(ilb_pkg::KIND_APPEND, 5'd0,  WORD_MIN,      5'd0);
        request(ilb_pkg::KIND_APPEND, 5'd31, WORD_MAX,      5'd31);
        request(ilb_pkg::KIND_INSERT, 5'd0,  32'hFFFF_FFFF, 5'd0);
        request(ilb_pkg::KIND_INSERT, 5'd3,  32'h0,         5'd0);
        request(ilb_pkg::KIND_READ,   5'd0,  32'h0,         5'd0);
        request(ilb_pkg::KIND_READ,   5'd3,  32'h0,         5'd0);
        request(ilb_pkg::KIND_READ,   5'd4,  32'h0,         5'd0);
        request(ilb_pkg::KIND_READ,   5'd31, 32'h0,         5'd0);
        request(ilb_pkg::KIND_DELETE, 5'd4,  32'h0,         5'd0);
        request(ilb_pkg::KIND_DELETE, 5'd31, 32'h0,         5'd0);
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            request(3'(k), 5'd31, 32'hFFFF_FFFF, 5'd31);
        request(ilb_pkg::KIND_PAD,    5'd0,  32'h1111_1111, 5'd3);
        request(ilb_pkg::KIND_PAD,    5'd0,  32'h5A5A_A5A5, 5'd16);
        request(ilb_pkg::KIND_APPEND, 5'd0,  32'h2222_2222, 5'd0);
        request(ilb_pkg::KIND_INSERT, 5'd16, 32'h3333_3333, 5'd0);
        request(ilb_pkg::KIND_INSERT, 5'd17, 32'h4444_4444, 5'd0);
        request(ilb_pkg::KIND_PAD,    5'd0,  32'h5555_5555, 5'd31);
        request(ilb_pkg::KIND_DELETE, 5'd15, 32'h0,         5'd0);
        request(ilb_pkg::KIND_DELETE, 5'd0,  32'h0,         5'd0);
        request(ilb_pkg::KIND_READ,   5'd13, 32'h0,         5'd0);
        request(ilb_pkg::KIND_PAD,    5'd0,  32'h6666_6666, 5'd20);
        drain_results();

        // Random part: sizes hover around half full, with occasional pads and stray indexes.
        while (counted < RANDOM_ITEMS) begin
            next_slot();
            pick   = $urandom_range(0, 99);
            target = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 17))
                                                : 5'($urandom_range(0, 31));
            if (pick < 3)
                kind_bits = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else if (pick < 10)
                kind_bits = ilb_pkg::KIND_PAD;
            else if (pick < 30)
                kind_bits = ilb_pkg::KIND_READ;
            else if ($urandom_range(0, LIST_DEPTH) > list_fill)
                kind_bits = ($urandom_range(0, 1) == 0) ? ilb_pkg::KIND_APPEND
                                                        : ilb_pkg::KIND_INSERT;
            else
                kind_bits = ilb_pkg::KIND_DELETE;
            // Insert may use the count itself; delete and read stop one short.
            span = (kind_bits == ilb_pkg::KIND_INSERT) ? list_fill
                                                       : ((list_fill > 0) ? list_fill - 1 : 0);
            if ($urandom_range(0, 3) != 0)
                pos = 5'($urandom_range(0, span));
            else
                pos = 5'($urandom_range(0, 31));
            send_beat(make_beat(kind_bits, pos, pick_word(), target));
            if (kind_bits < KIND_SPARE_LO) begin
                counted++;
                if (counted >= CALM_FROM)
                    calm = 1'b1;
                if (counted % 200 == 100)
                    drain_results();
            end
        end

        // Wind down: wait for the last results, then a little longer for strays.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("indexed_list_buffer_core_test: done, clean");
        else
            $display("indexed_list_buffer_core_test: done, errors");
        $finish;
    end

endmodule
